[design/bsl_pkg.sv]
`timescale 1ns / 1ps

package bsl_pkg;

	localparam int NUMBER_BITS = 32;
	localparam int POS_W = 16;
	localparam int LEN_W = 16;
	localparam int KW_COUNT = 6;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_EQ     = 2'd3
	} scan_mode_t;

	typedef enum logic [4:0] {
		TK_EOF     = 5'd0,
		TK_IDENT   = 5'd1,
		TK_NUMBER  = 5'd2,
		TK_LET     = 5'd3,
		TK_IF      = 5'd4,
		TK_ELSE    = 5'd5,
		TK_WHILE   = 5'd6,
		TK_PRINT   = 5'd7,
		TK_DO      = 5'd8,
		TK_EQEQ    = 5'd9,
		TK_PLUS    = 5'd10,
		TK_MINUS   = 5'd11,
		TK_STAR    = 5'd12,
		TK_SLASH   = 5'd13,
		TK_ASSIGN  = 5'd14,
		TK_LT      = 5'd15,
		TK_GT      = 5'd16,
		TK_LPAREN  = 5'd17,
		TK_RPAREN  = 5'd18,
		TK_LBRACE  = 5'd19,
		TK_RBRACE  = 5'd20,
		TK_SEMI    = 5'd21,
		TK_UNKNOWN = 5'd22
	} token_kind_t;

	typedef struct packed {
		token_kind_t             kind;
		logic [NUMBER_BITS-1:0]  value;
		logic                    saturated;
		logic [POS_W-1:0]        start;
		logic [LEN_W-1:0]        length;
		logic                    last;
	} token_t;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_EQUALS     = 8'h3D;
	localparam logic [7:0] CH_ZERO       = 8'h30;

	// Length of each keyword, in the order of the candidate mask.
	function automatic logic [2:0] kw_len(input int k);
		logic [2:0] len;
		unique case (k)
			0: len = 3'd3;
			1: len = 3'd2;
			2: len = 3'd4;
			3: len = 3'd5;
			4: len = 3'd5;
			default: len = 3'd2;
		endcase
		return len;
	endfunction

	// Character of keyword k at index idx; unused places hold zero.
	function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
		logic [39:0] text;
		logic [7:0] ch;
		unique case (k)
			0: text = {"let", 16'h0};
			1: text = {"if", 24'h0};
			2: text = {"else", 8'h0};
			3: text = "while";
			4: text = "print";
			default: text = {"do", 24'h0};
		endcase
		unique case (idx)
			3'd0: ch = text[39:32];
			3'd1: ch = text[31:24];
			3'd2: ch = text[23:16];
			3'd3: ch = text[15:8];
			3'd4: ch = text[7:0];
			default: ch = 8'h0;
		endcase
		return ch;
	endfunction

	function automatic token_kind_t op_kind(input logic [7:0] c);
		token_kind_t kind;
		unique case (c)
			"+": kind = TK_PLUS;
			"-": kind = TK_MINUS;
			"*": kind = TK_STAR;
			"/": kind = TK_SLASH;
			"<": kind = TK_LT;
			">": kind = TK_GT;
			"(": kind = TK_LPAREN;
			")": kind = TK_RPAREN;
			"{": kind = TK_LBRACE;
			"}": kind = TK_RBRACE;
			";": kind = TK_SEMI;
			default: kind = TK_UNKNOWN;
		endcase
		return kind;
	endfunction

endpackage

[design/byte_stream_lexer.sv]
`timescale 1ns / 1ps

// Byte stream lexer: takes one ASCII source byte per word and returns tokens
// with kind, start offset, length and, for numbers, a saturating 32-bit value.
// A byte is registered, classified against the scanner state when there is
// room, and its zero, one or two tokens are written into a four-word result
// queue. A byte is accepted in every cycle while the queue has room for two
// tokens, so input runs at one byte per cycle and is limited only by the
// output side taking one token per cycle. A token closed by a byte comes out
// before that byte's own token; "last" marks the final token of a byte. Byte 0
// ends the source: it reports eof and restarts offsets at zero.
module byte_stream_lexer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          source_valid,
	output logic                          source_stall,
	input  logic [7:0]                    source_byte,
	output logic                          token_valid,
	input  logic                          token_stall,
	output logic [4:0]                    token_kind,
	output logic [bsl_pkg::NUMBER_BITS-1:0] number_value,
	output logic                          number_saturated,
	output logic [bsl_pkg::POS_W-1:0]     token_start,
	output logic [bsl_pkg::LEN_W-1:0]     token_length,
	output logic                          last
);
	import bsl_pkg::*;

	logic                   valid_s1;
	logic [7:0]             byte_s1;

	scan_mode_t             mode_q, mode_n;
	logic [KW_COUNT-1:0]    kw_q, kw_n;
	logic [NUMBER_BITS-1:0] acc_q, acc_n;
	logic                   ovf_q, ovf_n;
	logic [POS_W-1:0]       begin_q, begin_n;
	logic [LEN_W-1:0]       count_q, count_n;
	logic [POS_W-1:0]       pos_q, pos_n;

	token_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wptr_q, rptr_q;
	logic [FIFO_CNT_W-1:0]  fcount_q;

	logic                   room;
	logic                   process;
	logic                   pop;
	logic [1:0]             n_res;
	token_t                 res0, res1;

	logic                   c_alpha, c_digit, c_space, c_idchar;
	logic [3:0]             digit;
	logic [NUMBER_BITS+3:0] acc_x10;
	logic [NUMBER_BITS+3:0] acc_next_wide;
	logic [LEN_W-1:0]       count_inc;
	logic [KW_COUNT-1:0]    kw_cont, kw_first;
	token_kind_t            ident_kind;

	assign room         = fcount_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign process      = valid_s1 && room;
	assign source_stall = valid_s1 && !room;
	assign token_valid  = fcount_q != '0;
	assign pop          = token_valid && !token_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!source_stall) begin
			valid_s1 <= source_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (source_valid && !source_stall) begin
			byte_s1 <= source_byte;
		end
	end

	// Character classes of the byte under work.
	always_comb begin
		c_alpha  = (byte_s1 >= "a" && byte_s1 <= "z") || (byte_s1 >= "A" && byte_s1 <= "Z");
		c_digit  = byte_s1 >= "0" && byte_s1 <= "9";
		c_space  = byte_s1 == " " || (byte_s1 >= 8'd9 && byte_s1 <= 8'd13);
		c_idchar = c_alpha || c_digit || byte_s1 == CH_UNDERSCORE;
		digit    = 4'(byte_s1 - CH_ZERO);
	end

	// acc * 10 + d, computed wide; it saturates when it no longer fits.
	assign acc_x10       = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
	assign acc_next_wide = acc_x10 + (NUMBER_BITS + 4)'(digit);
	assign count_inc     = (count_q == '1) ? count_q : count_q + 1'b1;

	// Keyword candidates that survive this character, and the fresh mask for
	// the first character of an identifier.
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			kw_cont[k]  = kw_q[k] && (count_q < LEN_W'(kw_len(k)))
				&& (kw_char(k, count_q[2:0]) == byte_s1);
			kw_first[k] = kw_char(k, 3'd0) == byte_s1;
		end
	end

	always_comb begin
		ident_kind = TK_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (kw_q[k] && count_q == LEN_W'(kw_len(k))) begin
				ident_kind = token_kind_t'(5'(int'(TK_LET) + k));
			end
		end
	end

	always_comb begin
		token_t pend;
		token_t own;
		logic   has_pend;
		logic   has_own;
		logic   consumed;

		mode_n   = mode_q;
		kw_n     = kw_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		begin_n  = begin_q;
		count_n  = count_q;
		pos_n    = (byte_s1 == 8'h00) ? '0 : pos_q + 1'b1;

		pend     = '{kind: TK_IDENT, value: '0, saturated: 1'b0, start: begin_q,
			length: count_q, last: 1'b0};
		own      = '{kind: TK_EOF, value: '0, saturated: 1'b0, start: pos_q,
			length: LEN_W'(1), last: 1'b0};
		has_pend = 1'b0;
		has_own  = 1'b0;
		consumed = 1'b0;

		unique case (mode_q)
			MODE_IDENT: begin
				if (c_idchar) begin
					kw_n     = kw_cont;
					count_n  = count_inc;
					consumed = 1'b1;
				end else begin
					pend.kind = ident_kind;
					has_pend  = 1'b1;
					mode_n    = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (c_digit) begin
					if (acc_next_wide[NUMBER_BITS+3:NUMBER_BITS] != '0) begin
						acc_n = '1;
						ovf_n = 1'b1;
					end else begin
						acc_n = acc_next_wide[NUMBER_BITS-1:0];
					end
					count_n  = count_inc;
					consumed = 1'b1;
				end else begin
					pend.kind      = TK_NUMBER;
					pend.value     = acc_q;
					pend.saturated = ovf_q;
					has_pend       = 1'b1;
					mode_n         = MODE_IDLE;
				end
			end
			MODE_EQ: begin
				mode_n   = MODE_IDLE;
				has_pend = 1'b1;
				if (byte_s1 == CH_EQUALS) begin
					pend.kind   = TK_EQEQ;
					pend.length = LEN_W'(2);
					consumed    = 1'b1;
				end else begin
					pend.kind   = TK_ASSIGN;
					pend.length = LEN_W'(1);
				end
			end
			default: begin
			end
		endcase

		if (!consumed) begin
			priority if (byte_s1 == 8'h00) begin
				own.kind   = TK_EOF;
				own.length = '0;
				has_own    = 1'b1;
			end else if (c_space) begin
			end else if (c_alpha || byte_s1 == CH_UNDERSCORE) begin
				mode_n  = MODE_IDENT;
				begin_n = pos_q;
				kw_n    = kw_first;
				count_n = LEN_W'(1);
			end else if (c_digit) begin
				mode_n  = MODE_NUMBER;
				begin_n = pos_q;
				count_n = LEN_W'(1);
				ovf_n   = 1'b0;
				acc_n   = NUMBER_BITS'(digit);
			end else if (byte_s1 == CH_EQUALS) begin
				mode_n  = MODE_EQ;
				begin_n = pos_q;
				count_n = LEN_W'(1);
			end else begin
				own.kind = op_kind(byte_s1);
				has_own  = 1'b1;
			end
		end

		if (byte_s1 == 8'h00) begin
			mode_n = MODE_IDLE;
		end

		// The pending token goes first; the last word of the byte is flagged.
		if (has_pend) begin
			res0      = pend;
			res1      = own;
			res0.last = !has_own;
			res1.last = 1'b1;
		end else begin
			res0      = own;
			res1      = own;
			res0.last = 1'b1;
			res1.last = 1'b1;
		end
		n_res = 2'(has_pend) + 2'(has_own);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			kw_q    <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			begin_q <= '0;
			count_q <= '0;
			pos_q   <= '0;
		end else if (process) begin
			mode_q  <= mode_n;
			kw_q    <= kw_n;
			acc_q   <= acc_n;
			ovf_q   <= ovf_n;
			begin_q <= begin_n;
			count_q <= count_n;
			pos_q   <= pos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			rptr_q   <= '0;
			fcount_q <= '0;
		end else begin
			if (process) begin
				wptr_q <= wptr_q + FIFO_PTR_W'(n_res);
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			fcount_q <= fcount_q + (process ? FIFO_CNT_W'(n_res) : '0)
				- FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (process && n_res != 2'd0) begin
			fifo_q[wptr_q] <= res0;
		end
		if (process && n_res == 2'd2) begin
			fifo_q[wptr_q + 1'b1] <= res1;
		end
	end

	assign token_kind       = fifo_q[rptr_q].kind;
	assign number_value     = fifo_q[rptr_q].value;
	assign number_saturated = fifo_q[rptr_q].saturated;
	assign token_start      = fifo_q[rptr_q].start;
	assign token_length     = fifo_q[rptr_q].length;
	assign last             = fifo_q[rptr_q].last;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(process && byte_s1 == 8'h00) |=> (pos_q == '0 && mode_q == MODE_IDLE))
		else $error("end of source did not restart the scanner");

	a_idle_single: assert property (@(posedge clk) disable iff (!arst_n)
		(process && mode_q == MODE_IDLE) |-> n_res <= 2'd1)
		else $error("two tokens from a byte with nothing pending");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fcount_q == '0) |=> (rptr_q == $past(rptr_q)))
		else $error("read pointer moved on an empty queue");

endmodule
